// ===== rtl/crc8_packet_framer_assert.svh =====
// Assertion macros shared by the framer modules.
// Each expects a clock named clk and a reset named rst in scope.
`ifndef CRC8_PACKET_FRAMER_ASSERT_SVH
`define CRC8_PACKET_FRAMER_ASSERT_SVH

// Checked only outside reset.
`define CPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define CPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/cpf_pkg.sv =====
package cpf_pkg;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  localparam logic [7:0] SYNC_RESET   = 8'd170;
  localparam logic [7:0] LENGTH_RESET = 8'd32;

  // Configuration register indexes
  localparam logic REG_SYNC   = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

  // Output byte positions within the group one payload byte causes
  typedef enum logic [1:0] {
    SLOT_SYNC    = 2'd0,
    SLOT_LENGTH  = 2'd1,
    SLOT_PAYLOAD = 2'd2,
    SLOT_CRC     = 2'd3
  } slot_t;

  // Everything the output side needs for one accepted payload byte
  typedef struct packed {
    logic       has_head;
    logic       has_crc;
    logic [7:0] sync_byte;
    logic [7:0] length_byte;
    logic [7:0] data_byte;
    logic [7:0] crc_byte;
  } grp_t;

  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/crc8_packet_framer.sv =====
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+---------------------------------
// input    | in        | in_valid / in_ready | payload_byte[7:0]
// output   | out       | out_valid/out_ready | frame_byte[7:0], frame_end
// config   | in        | cfg_write           | cfg_index, cfg_data[7:0]
//
// Each payload byte yields 1 to 4 output transfers (sync and length before the first
// byte of a frame, crc after the last); one output transfer per cycle unless stalled.
// A payload byte is taken in the cycle the last output of the previous byte leaves, so
// mid-frame bytes flow at one per cycle unless stalled; the output register sets the
// rate. Output appears in the cycle after the input transfer. Reset is synchronous:
// registers return to sync 170, length 32, counter and crc clear, output empty. A
// stalled output holds its byte; input is held off until the last pending byte leaves.

module crc8_packet_framer
  import cpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] payload_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] frame_byte,
  output logic       frame_end
);

  grp_t grp;
  logic xfer;

  assign xfer = in_valid && in_ready;

  cpf_frame_ctl u_frame_ctl (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .xfer         (xfer),
    .payload_byte (payload_byte),
    .grp          (grp)
  );

  cpf_out_seq u_out_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .grp_in     (grp),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .frame_end  (frame_end)
  );

endmodule

// ===== rtl/cpf_frame_ctl.sv =====
`include "crc8_packet_framer_assert.svh"

module cpf_frame_ctl
  import cpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       xfer,
  input  logic [7:0] payload_byte,
  output grp_t       grp
);

  logic [7:0] sync_value;
  logic [7:0] payload_length;
  logic [7:0] bytes_taken;
  logic [7:0] running_crc;
  logic [7:0] bytes_taken_next;
  logic [7:0] running_crc_next;

  logic       head;
  logic       end_hit;
  logic [7:0] crc_new;
  logic [7:0] count_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value     <= SYNC_RESET;
      payload_length <= LENGTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SYNC:   sync_value     <= cfg_data;
        REG_LENGTH: payload_length <= cfg_data;
        default:    sync_value     <= sync_value;
      endcase
    end
  end

  always_comb begin
    head      = (bytes_taken == 8'd0);
    crc_new   = crc8_fold(head ? CRC_INIT : running_crc, payload_byte);
    count_new = bytes_taken + 8'd1;
    end_hit   = (count_new == payload_length);

    bytes_taken_next = end_hit ? 8'd0 : count_new;
    running_crc_next = end_hit ? CRC_INIT : crc_new;

    grp.has_head    = head;
    grp.has_crc     = end_hit;
    grp.sync_byte   = sync_value;
    grp.length_byte = payload_length;
    grp.data_byte   = payload_byte;
    grp.crc_byte    = crc_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_taken <= 8'd0;
      running_crc <= CRC_INIT;
    end else if (xfer) begin
      bytes_taken <= bytes_taken_next;
      running_crc <= running_crc_next;
    end
  end

  `CPF_ASSERT(a_end_clears_crc, (xfer && end_hit) |=> (running_crc == CRC_INIT), "crc kept")
  `CPF_ASSERT(a_end_restarts, (xfer && end_hit) |=> (bytes_taken == 8'd0), "no restart after crc")
  `CPF_ASSERT(a_count_holds, !xfer |=> $stable(bytes_taken), "count moved without transfer")

endmodule

// ===== rtl/cpf_out_seq.sv =====
`include "crc8_packet_framer_assert.svh"

module cpf_out_seq
  import cpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  grp_t       grp_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] frame_byte,
  output logic       frame_end
);

  logic  valid;
  grp_t  grp;
  slot_t slot;
  slot_t slot_next;
  logic  last;
  logic  take;
  logic  load;

  always_comb begin
    last     = (slot == SLOT_CRC) || ((slot == SLOT_PAYLOAD) && !grp.has_crc);
    take     = valid && out_ready;
    in_ready = !valid || (take && last);
    load     = in_valid && in_ready;

    case (slot)
      SLOT_SYNC:    slot_next = SLOT_LENGTH;
      SLOT_LENGTH:  slot_next = SLOT_PAYLOAD;
      SLOT_PAYLOAD: slot_next = SLOT_CRC;
      default:      slot_next = SLOT_CRC;
    endcase
  end

  always_comb begin
    case (slot)
      SLOT_SYNC:    frame_byte = grp.sync_byte;
      SLOT_LENGTH:  frame_byte = grp.length_byte;
      SLOT_PAYLOAD: frame_byte = grp.data_byte;
      default:      frame_byte = grp.crc_byte;
    endcase

    out_valid = valid;
    frame_end = (slot == SLOT_CRC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      slot  <= SLOT_PAYLOAD;
    end else if (load) begin
      valid <= 1'b1;
      slot  <= grp_in.has_head ? SLOT_SYNC : SLOT_PAYLOAD;
    end else if (take) begin
      // drop the group after its last byte, else advance
      if (last) begin
        valid <= 1'b0;
      end else begin
        slot <= slot_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

  `CPF_ASSERT(a_load_shows, (in_valid && in_ready) |=> out_valid, "accepted byte not presented")
  `CPF_ASSERT(a_block_when_full, !in_ready |-> out_valid, "input held off with nothing pending")
  `CPF_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid after reset")

endmodule
